// File: design/ajb_pkg.sv
`timescale 1ns / 1ps

package ajb_pkg;

    // Ring geometry.
    localparam int SLOTS   = 16;
    localparam int SAMPLES = 32;

    localparam int SLOT_W = (SLOTS > 1) ? $clog2(SLOTS) : 1;
    localparam int POS_W  = (SAMPLES > 1) ? $clog2(SAMPLES) : 1;
    localparam int CNT_W  = $clog2(SLOTS + 1);
    localparam int ADDR_W = $clog2(SLOTS * SAMPLES);
    localparam int DATA_W = 16;
    localparam int REG_W  = 5;
    localparam int IDX_W  = 1;

    // Configuration register indexes.
    localparam logic [IDX_W-1:0] REG_PREBUFFER_MIN  = 1'd0;
    localparam logic [IDX_W-1:0] REG_OVERFLOW_LEVEL = 1'd1;

    typedef enum logic [2:0] {
        ACT_PUSH  = 3'd0,
        ACT_POP   = 3'd1,
        ACT_QUERY = 3'd2,
        ACT_FLUSH = 3'd3,
        ACT_RESET = 3'd4
    } action_t;

    typedef enum logic [2:0] {
        ST_STORED    = 3'd0,
        ST_DUPLICATE = 3'd1,
        ST_FULL      = 3'd2,
        ST_FRAME     = 3'd3,
        ST_UNDERRUN  = 3'd4,
        ST_READY     = 3'd5,
        ST_CLEARED   = 3'd6
    } status_t;

    typedef struct packed {
        status_t            status;
        logic signed [15:0] sample_out;
        logic               frame_last;
        logic [4:0]         fill_level;
        logic               ready_res;
        logic [31:0]        received_total;
        logic [31:0]        dropped_total;
        logic [31:0]        lost_total;
        logic [31:0]        underrun_total;
    } ajb_result_t;

    typedef struct packed {
        logic              we;
        logic [ADDR_W-1:0] waddr;
        logic [DATA_W-1:0] wdata;
        logic              re;
        logic [ADDR_W-1:0] raddr;
    } ajb_ram_req_t;

endpackage

// File: design/ajb_slot_ram.sv
`timescale 1ns / 1ps

module ajb_slot_ram #(
    parameter int DEPTH  = 512,
    parameter int WIDTH  = 16,
    parameter int ADDR_W = $clog2(DEPTH)
) (
    input  logic              aclk,
    input  logic              we,
    input  logic [ADDR_W-1:0] waddr,
    input  logic [WIDTH-1:0]  wdata,
    input  logic              re,
    input  logic [ADDR_W-1:0] raddr,
    output logic [WIDTH-1:0]  rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
    end

    // Read data holds while no read is issued.
    always_ff @(posedge aclk) begin
        if (re) begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

// File: design/ajb_result_fifo.sv
`timescale 1ns / 1ps

module ajb_result_fifo
    import ajb_pkg::*;
(
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        push,
    input  ajb_result_t push_data,
    output logic        room,
    output logic        out_valid,
    input  logic        out_ready,
    output ajb_result_t out_data
);

    ajb_result_t entry_reg [2];
    logic        wr_ptr_reg, wr_ptr_next;
    logic        rd_ptr_reg, rd_ptr_next;
    logic [1:0]  count_reg, count_next;
    logic        pop;

    assign room      = (count_reg != 2'd2);
    assign out_valid = (count_reg != 2'd0);
    assign out_data  = entry_reg[rd_ptr_reg];
    assign pop       = out_valid && out_ready;

    always_comb begin
        wr_ptr_next = push ? ~wr_ptr_reg : wr_ptr_reg;
        rd_ptr_next = pop ? ~rd_ptr_reg : rd_ptr_reg;
        count_next  = count_reg + 2'(push) - 2'(pop);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (push) begin
            entry_reg[wr_ptr_reg] <= push_data;
        end
    end

endmodule

// File: design/ajb_ctrl.sv
`timescale 1ns / 1ps

module ajb_ctrl
    import ajb_pkg::*;
(
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               cfg_wr_en,
    input  logic [IDX_W-1:0]   cfg_index,
    input  logic [REG_W-1:0]   cfg_data,
    input  logic               in_valid,
    output logic               in_ready,
    input  logic [2:0]         in_action,
    input  logic [31:0]        in_seq,
    input  logic signed [15:0] in_sample,
    input  logic               res_room,
    output logic               res_push,
    output ajb_result_t        res_data,
    output ajb_ram_req_t       ram_req,
    input  logic [DATA_W-1:0]  ram_rdata
);

    typedef enum logic [2:0] {
        S_IDLE  = 3'b001,
        S_FRAME = 3'b010,
        S_UNDER = 3'b100
    } state_t;

    state_t              state_reg, state_next;
    logic [REG_W-1:0]    prebuf_reg, prebuf_next;
    logic [REG_W-1:0]    ovf_reg, ovf_next;
    logic [SLOT_W-1:0]   wr_slot_reg, wr_slot_next;
    logic [SLOT_W-1:0]   rd_slot_reg, rd_slot_next;
    logic [SLOT_W-1:0]   pop_slot_reg, pop_slot_next;
    logic [CNT_W-1:0]    held_reg, held_next;
    logic                started_reg, started_next;
    logic                known_reg, known_next;
    logic [31:0]         exp_seq_reg, exp_seq_next;
    logic [POS_W-1:0]    pos_reg, pos_next;
    logic                kept_reg, kept_next;
    logic                full_drop_reg, full_drop_next;
    logic [31:0]         rx_reg, rx_next;
    logic [31:0]         drop_reg, drop_next;
    logic [31:0]         loss_reg, loss_next;
    logic [31:0]         under_reg, under_next;
    logic [POS_W-1:0]    issue_pos_reg, issue_pos_next;
    logic                issue_done_reg, issue_done_next;
    logic                rd_valid_reg, rd_valid_next;
    logic [POS_W-1:0]    out_pos_reg, out_pos_next;

    logic                in_fire;
    logic                seq_push;
    logic                seq_issue;
    logic                item_push;
    status_t             item_status;
    logic                out_last;

    function automatic logic [SLOT_W-1:0] slot_inc(input logic [SLOT_W-1:0] s);
        slot_inc = (32'(s) == SLOTS - 1) ? '0 : s + SLOT_W'(1);
    endfunction

    assign in_ready = (state_reg == S_IDLE) && res_room;
    assign in_fire  = in_valid && in_ready;
    assign out_last = (32'(out_pos_reg) == SAMPLES - 1);

    always_comb begin
        state_next      = state_reg;
        prebuf_next     = prebuf_reg;
        ovf_next        = ovf_reg;
        wr_slot_next    = wr_slot_reg;
        rd_slot_next    = rd_slot_reg;
        pop_slot_next   = pop_slot_reg;
        held_next       = held_reg;
        started_next    = started_reg;
        known_next      = known_reg;
        exp_seq_next    = exp_seq_reg;
        pos_next        = pos_reg;
        kept_next       = kept_reg;
        full_drop_next  = full_drop_reg;
        rx_next         = rx_reg;
        drop_next       = drop_reg;
        loss_next       = loss_reg;
        under_next      = under_reg;
        issue_pos_next  = issue_pos_reg;
        issue_done_next = issue_done_reg;
        rd_valid_next   = rd_valid_reg;
        out_pos_next    = out_pos_reg;
        item_push       = 1'b0;
        item_status     = ST_STORED;
        seq_push        = 1'b0;
        seq_issue       = 1'b0;
        ram_req.we      = 1'b0;
        ram_req.waddr   = '0;
        ram_req.wdata   = in_sample;

        if (cfg_wr_en) begin
            case (cfg_index)
                REG_PREBUFFER_MIN:  prebuf_next = cfg_data;
                REG_OVERFLOW_LEVEL: ovf_next = cfg_data;
                default: ;
            endcase
        end

        case (state_reg)
            S_FRAME: begin
                seq_push  = rd_valid_reg && res_room;
                seq_issue = !issue_done_reg && (!rd_valid_reg || seq_push);
                if (seq_issue) begin
                    issue_pos_next  = issue_pos_reg + POS_W'(1);
                    issue_done_next = (32'(issue_pos_reg) == SAMPLES - 1);
                end
                rd_valid_next = seq_issue ? 1'b1 : (seq_push ? 1'b0 : rd_valid_reg);
                if (seq_push) begin
                    out_pos_next = out_pos_reg + POS_W'(1);
                    if (out_last) begin
                        state_next = S_IDLE;
                    end
                end
            end
            S_UNDER: begin
                seq_push = res_room;
                if (seq_push) begin
                    out_pos_next = out_pos_reg + POS_W'(1);
                    if (out_last) begin
                        state_next = S_IDLE;
                    end
                end
            end
            default: begin
                if (in_fire) begin
                    case (in_action)
                        ACT_PUSH: begin
                            if (pos_reg == '0) begin
                                rx_next   = rx_reg + 32'd1;
                                kept_next = 1'b0;
                                if (known_reg && (in_seq < exp_seq_reg)) begin
                                    drop_next      = drop_reg + 32'd1;
                                    full_drop_next = 1'b0;
                                end else begin
                                    if (known_reg && (in_seq > exp_seq_reg)) begin
                                        loss_next    = loss_reg + (in_seq - exp_seq_reg);
                                        wr_slot_next = '0;
                                        rd_slot_next = '0;
                                        held_next    = '0;
                                        started_next = 1'b0;
                                    end
                                    exp_seq_next = in_seq + 32'd1;
                                    known_next   = 1'b1;
                                    if (32'(held_next) >= 32'(ovf_reg)) begin
                                        wr_slot_next = '0;
                                        rd_slot_next = '0;
                                        held_next    = '0;
                                        started_next = 1'b0;
                                    end
                                    if (32'(held_next) >= SLOTS) begin
                                        drop_next      = drop_reg + 32'd1;
                                        full_drop_next = 1'b1;
                                    end else begin
                                        kept_next = 1'b1;
                                    end
                                end
                            end
                            ram_req.we    = kept_next;
                            ram_req.waddr = ADDR_W'(32'(wr_slot_next) * SAMPLES
                                                    + 32'(pos_reg));
                            if (32'(pos_reg) == SAMPLES - 1) begin
                                pos_next  = '0;
                                item_push = 1'b1;
                                if (kept_next) begin
                                    wr_slot_next = slot_inc(wr_slot_next);
                                    held_next    = held_next + CNT_W'(1);
                                    kept_next    = 1'b0;
                                    item_status  = ST_STORED;
                                end else begin
                                    item_status = full_drop_next ? ST_FULL : ST_DUPLICATE;
                                end
                            end else begin
                                pos_next = pos_reg + POS_W'(1);
                            end
                        end
                        ACT_POP: begin
                            pos_next     = '0;
                            kept_next    = 1'b0;
                            out_pos_next = '0;
                            if (held_reg == '0) begin
                                under_next   = under_reg + 32'd1;
                                started_next = 1'b0;
                                state_next   = S_UNDER;
                            end else begin
                                pop_slot_next   = rd_slot_reg;
                                rd_slot_next    = slot_inc(rd_slot_reg);
                                held_next       = held_reg - CNT_W'(1);
                                issue_pos_next  = '0;
                                issue_done_next = 1'b0;
                                rd_valid_next   = 1'b0;
                                state_next      = S_FRAME;
                            end
                        end
                        ACT_QUERY: begin
                            pos_next  = '0;
                            kept_next = 1'b0;
                            if (!started_reg && (32'(held_reg) >= 32'(prebuf_reg))) begin
                                started_next = 1'b1;
                            end
                            item_push   = 1'b1;
                            item_status = ST_READY;
                        end
                        ACT_FLUSH: begin
                            pos_next     = '0;
                            kept_next    = 1'b0;
                            wr_slot_next = '0;
                            rd_slot_next = '0;
                            held_next    = '0;
                            started_next = 1'b0;
                            known_next   = 1'b0;
                            item_push    = 1'b1;
                            item_status  = ST_CLEARED;
                        end
                        ACT_RESET: begin
                            pos_next       = '0;
                            kept_next      = 1'b0;
                            wr_slot_next   = '0;
                            rd_slot_next   = '0;
                            held_next      = '0;
                            started_next   = 1'b0;
                            known_next     = 1'b0;
                            exp_seq_next   = '0;
                            full_drop_next = 1'b0;
                            rx_next        = '0;
                            drop_next      = '0;
                            loss_next      = '0;
                            under_next     = '0;
                            item_push      = 1'b1;
                            item_status    = ST_CLEARED;
                        end
                        default: ;
                    endcase
                end
            end
        endcase

        ram_req.re    = seq_issue;
        ram_req.raddr = ADDR_W'(32'(pop_slot_reg) * SAMPLES + 32'(issue_pos_reg));
    end

    // Single results carry the state after the item; frame results carry the
    // state that the pop left, which stays put until the frame is out.
    always_comb begin
        res_push = item_push || seq_push;
        if (state_reg == S_IDLE) begin
            res_data.status         = item_status;
            res_data.sample_out     = '0;
            res_data.frame_last     = 1'b1;
            res_data.fill_level     = 5'(held_next);
            res_data.ready_res      = started_next;
            res_data.received_total = rx_next;
            res_data.dropped_total  = drop_next;
            res_data.lost_total     = loss_next;
            res_data.underrun_total = under_next;
        end else begin
            res_data.status         = (state_reg == S_FRAME) ? ST_FRAME : ST_UNDERRUN;
            res_data.sample_out     = (state_reg == S_FRAME) ? ram_rdata : '0;
            res_data.frame_last     = out_last;
            res_data.fill_level     = 5'(held_reg);
            res_data.ready_res      = started_reg;
            res_data.received_total = rx_reg;
            res_data.dropped_total  = drop_reg;
            res_data.lost_total     = loss_reg;
            res_data.underrun_total = under_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg      <= S_IDLE;
            prebuf_reg     <= REG_W'(4);
            ovf_reg        <= REG_W'(12);
            wr_slot_reg    <= '0;
            rd_slot_reg    <= '0;
            held_reg       <= '0;
            started_reg    <= 1'b0;
            known_reg      <= 1'b0;
            exp_seq_reg    <= '0;
            pos_reg        <= '0;
            kept_reg       <= 1'b0;
            full_drop_reg  <= 1'b0;
            rx_reg         <= '0;
            drop_reg       <= '0;
            loss_reg       <= '0;
            under_reg      <= '0;
            issue_done_reg <= 1'b0;
            rd_valid_reg   <= 1'b0;
        end else begin
            state_reg      <= state_next;
            prebuf_reg     <= prebuf_next;
            ovf_reg        <= ovf_next;
            wr_slot_reg    <= wr_slot_next;
            rd_slot_reg    <= rd_slot_next;
            held_reg       <= held_next;
            started_reg    <= started_next;
            known_reg      <= known_next;
            exp_seq_reg    <= exp_seq_next;
            pos_reg        <= pos_next;
            kept_reg       <= kept_next;
            full_drop_reg  <= full_drop_next;
            rx_reg         <= rx_next;
            drop_reg       <= drop_next;
            loss_reg       <= loss_next;
            under_reg      <= under_next;
            issue_done_reg <= issue_done_next;
            rd_valid_reg   <= rd_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        pop_slot_reg  <= pop_slot_next;
        issue_pos_reg <= issue_pos_next;
        out_pos_reg   <= out_pos_next;
    end

    a_held_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        32'(held_reg) <= SLOTS)
        else $error("ring level above slot count");

    a_push_has_room: assert property (@(posedge aclk) disable iff (!aresetn)
        res_push |-> res_room)
        else $error("result pushed into a full queue");

    a_rd_valid_in_frame: assert property (@(posedge aclk) disable iff (!aresetn)
        rd_valid_reg |-> (state_reg == S_FRAME))
        else $error("read data pending outside a frame");

    a_empty_pop_underruns: assert property (@(posedge aclk) disable iff (!aresetn)
        (in_fire && (in_action == ACT_POP) && (held_reg == '0)) |=>
            (state_reg == S_UNDER))
        else $error("pop on an empty ring did not underrun");

    a_no_write_while_busy: assert property (@(posedge aclk) disable iff (!aresetn)
        ram_req.we |-> (state_reg == S_IDLE))
        else $error("slot write during a frame read");

endmodule

// File: design/audio_jitter_buffer.sv
`timescale 1ns / 1ps
// The last push sample of a packet, a ready query, a flush or a reset-all transfer puts its
// result in the registered result queue for m_. A pop enters the frame state, which reads the
// slot memory and pushes each sample as its registered read data comes back; an underrun pop
// pushes samples of zero. Push, query, flush and reset-all go one per cycle while the queue has
// room; a pop holds s_ready low until its whole frame is in the queue, longer on m_ready stalls.
// Reset: aresetn is synchronous and active low; it clears the ring control, counters and result
// queue and loads the default registers. The slot memory is not cleared and needs no sweep.

module audio_jitter_buffer
    import ajb_pkg::*;
(
    input  logic               aclk,
    input  logic               aresetn,
    // Configuration write port.
    input  logic               cfg_wr_en,
    input  logic [IDX_W-1:0]   cfg_index,
    input  logic [REG_W-1:0]   cfg_data,
    // Input channel.
    input  logic               s_valid,
    output logic               s_ready,
    input  logic [2:0]         s_action,
    input  logic [31:0]        s_seq,
    input  logic signed [15:0] s_sample,
    // Result channel.
    output logic               m_valid,
    input  logic               m_ready,
    output logic [2:0]         m_status,
    output logic signed [15:0] m_sample_out,
    output logic               m_frame_last,
    output logic [4:0]         m_fill_level,
    output logic               m_ready_res,
    output logic [31:0]        m_received_total,
    output logic [31:0]        m_dropped_total,
    output logic [31:0]        m_lost_total,
    output logic [31:0]        m_underrun_total
);

    // The controller owns all ring state in registers and keeps the samples in
    // one synchronous slot memory. Results go through a two-entry queue, so a
    // result waiting on m_ready does not stop the next input transfer.

    ajb_ram_req_t        ram_req;
    logic [DATA_W-1:0]   ram_rdata;
    logic                res_push;
    logic                res_room;
    ajb_result_t         res_data;
    ajb_result_t         out_data;

    ajb_ctrl u_ctrl (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_wr_en (cfg_wr_en),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .in_valid  (s_valid),
        .in_ready  (s_ready),
        .in_action (s_action),
        .in_seq    (s_seq),
        .in_sample (s_sample),
        .res_room  (res_room),
        .res_push  (res_push),
        .res_data  (res_data),
        .ram_req   (ram_req),
        .ram_rdata (ram_rdata)
    );

    // Slot memory: one packet per row of SAMPLES entries.
    ajb_slot_ram #(
        .DEPTH  (SLOTS * SAMPLES),
        .WIDTH  (DATA_W),
        .ADDR_W (ADDR_W)
    ) u_slot_ram (
        .aclk  (aclk),
        .we    (ram_req.we),
        .waddr (ram_req.waddr),
        .wdata (ram_req.wdata),
        .re    (ram_req.re),
        .raddr (ram_req.raddr),
        .rdata (ram_rdata)
    );

    ajb_result_fifo u_result_fifo (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .push      (res_push),
        .push_data (res_data),
        .room      (res_room),
        .out_valid (m_valid),
        .out_ready (m_ready),
        .out_data  (out_data)
    );

    // Every result field travels through the queue as one record.
    assign m_status         = out_data.status;
    assign m_sample_out     = out_data.sample_out;
    assign m_frame_last     = out_data.frame_last;
    assign m_fill_level     = out_data.fill_level;
    assign m_ready_res      = out_data.ready_res;
    assign m_received_total = out_data.received_total;
    assign m_dropped_total  = out_data.dropped_total;
    assign m_lost_total     = out_data.lost_total;
    assign m_underrun_total = out_data.underrun_total;

endmodule
